FILE: rtl/core/mecanum_wheel_speed_mixer_unit_macros.svh
// assertion macros for the mecanum wheel speed mixer
// used by the top level only, no other dependencies
`ifndef MECANUM_WHEEL_SPEED_MIXER_UNIT_MACROS_SVH
`define MECANUM_WHEEL_SPEED_MIXER_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define MWSM_ASSERT_IMP(lbl, clk, rst_n, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("mwsm assertion failed");

// next-cycle implication, off during reset
`define MWSM_ASSERT_NEXT(lbl, clk, rst_n, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("mwsm assertion failed");

`endif

FILE: rtl/core/mwsm_pkg.sv
// shared constants and types for the mecanum wheel speed mixer
// no dependencies
`default_nettype none

package mwsm_pkg;

  localparam int NUM_WHEELS = 4;
  localparam int FIELD_W    = 16;
  localparam int MAG_W      = 15;
  localparam int PROD_W     = 2 * MAG_W;
  localparam int QUOT_W     = MAG_W;

  // command clamps and wheel saturation
  localparam logic signed [FIELD_W-1:0] VEL_XY_LIM = 16'sd14000;
  localparam logic signed [FIELD_W-1:0] ROT_LIM    = 16'sd10000;
  localparam logic signed [FIELD_W:0]   WHEEL_SAT  = 17'sd32767;

  localparam logic [MAG_W-1:0] LIMIT_RESET = 15'd6000;

  // quotient bits resolved per divider stage
  localparam int DIV_BITS_DEFAULT = 3;

  typedef logic [MAG_W-1:0] mag_t;

  // one item inside the divider: per-lane work word {remainder, dividend/quotient}
  typedef struct packed {
    logic [NUM_WHEELS-1:0][PROD_W-1:0]  work;
    mag_t                               divisor;
    logic [NUM_WHEELS-1:0]              neg;
    logic [NUM_WHEELS-1:0][FIELD_W-1:0] wheel;
    logic                               scale;
  } div_req_t;

endpackage

`default_nettype wire

FILE: rtl/core/mecanum_wheel_speed_mixer_unit.sv
// Mecanum wheel speed mixer, top level.
// A velocity command (in_vel_x, in_vel_y, in_rotation_rate) is transferred on the
// input channel when in_valid is high and in_stall is low; four wheel speeds
// leave on the output channel when out_valid is high and out_stall is low.
// cfg_wr_en writes cfg_wr_data into the wheel speed limit (reset value 6000);
// write it only while no command is in flight.
// Commands are clamped, mixed, saturated and, when the largest wheel magnitude
// is above the limit, every wheel is scaled by limit/max with truncation.
// The stages in order are clamp, mix, multiply/max, the divider stages and
// output select.
// Throughput is one command per cycle while out_stall is low; every stage is
// registered and the divider resolves DIV_BITS_PER_STAGE quotient bits per stage per lane.
// Reset (synchronous, rst_n low) empties the pipeline and restores the limit.
// A stall on the output holds the result; stages upstream keep filling any
// empty slot, so in_stall rises only once every stage holds a command.
`default_nettype none
`include "mecanum_wheel_speed_mixer_unit_macros.svh"

module mecanum_wheel_speed_mixer_unit #(
  parameter int DIV_BITS_PER_STAGE = mwsm_pkg::DIV_BITS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [14:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic signed [15:0] in_vel_x,
  input  wire logic signed [15:0] in_vel_y,
  input  wire logic signed [15:0] in_rotation_rate,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic signed [15:0] out_wheel_speed_0,
  output logic signed [15:0] out_wheel_speed_1,
  output logic signed [15:0] out_wheel_speed_2,
  output logic signed [15:0] out_wheel_speed_3
);

  localparam int NW = mwsm_pkg::NUM_WHEELS;
  localparam int FW = mwsm_pkg::FIELD_W;
  localparam int MW = mwsm_pkg::MAG_W;

  // limit register
  mwsm_pkg::mag_t limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= mwsm_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      limit_r <= cfg_wr_data;
    end
  end

  // ready chain
  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3, rdy_out;
  logic div_in_stall;
  logic div_out_valid;

  assign rdy_out  = !out_valid || !out_stall;
  assign rdy3     = !v3_r || !div_in_stall;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;

  // stage 1: clamp the command
  logic signed [MW-1:0] vx_r, vy_r, rot_r;
  logic signed [MW-1:0] vx_nxt, vy_nxt, rot_nxt;

  always_comb begin
    if (in_vel_x > mwsm_pkg::VEL_XY_LIM) begin
      vx_nxt = MW'(mwsm_pkg::VEL_XY_LIM);
    end else if (in_vel_x < -mwsm_pkg::VEL_XY_LIM) begin
      vx_nxt = MW'(-mwsm_pkg::VEL_XY_LIM);
    end else begin
      vx_nxt = in_vel_x[MW-1:0];
    end
    if (in_vel_y > mwsm_pkg::VEL_XY_LIM) begin
      vy_nxt = MW'(mwsm_pkg::VEL_XY_LIM);
    end else if (in_vel_y < -mwsm_pkg::VEL_XY_LIM) begin
      vy_nxt = MW'(-mwsm_pkg::VEL_XY_LIM);
    end else begin
      vy_nxt = in_vel_y[MW-1:0];
    end
    if (in_rotation_rate > mwsm_pkg::ROT_LIM) begin
      rot_nxt = MW'(mwsm_pkg::ROT_LIM);
    end else if (in_rotation_rate < -mwsm_pkg::ROT_LIM) begin
      rot_nxt = MW'(-mwsm_pkg::ROT_LIM);
    end else begin
      rot_nxt = in_rotation_rate[MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      vx_r  <= vx_nxt;
      vy_r  <= vy_nxt;
      rot_r <= rot_nxt;
    end
  end

  // stage 2: mix, saturate, take magnitudes
  logic signed [FW:0]   sum   [NW];
  logic signed [FW-1:0] wheel2_nxt [NW];
  mwsm_pkg::mag_t       mag2_nxt   [NW];
  logic signed [FW-1:0] wheel2_r [NW];
  mwsm_pkg::mag_t       mag2_r   [NW];

  always_comb begin
    logic signed [FW:0] ex, ey, er;
    ex = (FW+1)'(vx_r);
    ey = (FW+1)'(vy_r);
    er = (FW+1)'(rot_r);
    sum[0] = -ex + ey - er;
    sum[1] = -ex - ey - er;
    sum[2] =  ex - ey - er;
    sum[3] =  ex + ey - er;
    for (int i = 0; i < NW; i++) begin
      if (sum[i] > mwsm_pkg::WHEEL_SAT) begin
        wheel2_nxt[i] = FW'(mwsm_pkg::WHEEL_SAT);
      end else if (sum[i] < -mwsm_pkg::WHEEL_SAT) begin
        wheel2_nxt[i] = FW'(-mwsm_pkg::WHEEL_SAT);
      end else begin
        wheel2_nxt[i] = sum[i][FW-1:0];
      end
      mag2_nxt[i] = wheel2_nxt[i][FW-1] ? MW'(-wheel2_nxt[i]) : wheel2_nxt[i][MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      wheel2_r <= wheel2_nxt;
      mag2_r   <= mag2_nxt;
    end
  end

  // stage 3: largest magnitude, limit compare, products with the limit
  mwsm_pkg::mag_t     max01, max23, maxabs;
  mwsm_pkg::div_req_t req3_nxt, req3_r;

  always_comb begin
    max01  = (mag2_r[0] > mag2_r[1]) ? mag2_r[0] : mag2_r[1];
    max23  = (mag2_r[2] > mag2_r[3]) ? mag2_r[2] : mag2_r[3];
    maxabs = (max01 > max23) ? max01 : max23;
    req3_nxt.divisor = maxabs;
    req3_nxt.scale   = (maxabs > limit_r);
    for (int i = 0; i < NW; i++) begin
      req3_nxt.work[i]  = mwsm_pkg::PROD_W'(mag2_r[i]) * mwsm_pkg::PROD_W'(limit_r);
      req3_nxt.neg[i]   = wheel2_r[i][FW-1];
      req3_nxt.wheel[i] = wheel2_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      req3_r <= req3_nxt;
    end
  end

  // divider stages
  mwsm_pkg::div_req_t div_out_req;

  mwsm_div_pipe #(
    .BITS_PER_STAGE(DIV_BITS_PER_STAGE)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v3_r),
    .in_stall (div_in_stall),
    .in_req   (req3_r),
    .out_valid(div_out_valid),
    .out_stall(!rdy_out),
    .out_req  (div_out_req)
  );

  // output stage: pick scaled or raw wheel, restore sign
  logic signed [FW-1:0] wheel_out_nxt [NW];
  logic signed [FW-1:0] wheel_out_r   [NW];
  logic                 out_valid_r;

  always_comb begin
    logic signed [FW-1:0] q;
    for (int i = 0; i < NW; i++) begin
      q = $signed({1'b0, div_out_req.work[i][MW-1:0]});
      if (div_out_req.scale) begin
        wheel_out_nxt[i] = div_out_req.neg[i] ? -q : q;
      end else begin
        wheel_out_nxt[i] = $signed(div_out_req.wheel[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy_out) begin
      out_valid_r <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out && div_out_valid) begin
      wheel_out_r <= wheel_out_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_wheel_speed_0 = wheel_out_r[0];
  assign out_wheel_speed_1 = wheel_out_r[1];
  assign out_wheel_speed_2 = wheel_out_r[2];
  assign out_wheel_speed_3 = wheel_out_r[3];

  // no wheel ever carries the most negative code
  logic out_no_min_neg;

  assign out_no_min_neg = (out_wheel_speed_0 != 16'sh8000) && (out_wheel_speed_1 != 16'sh8000)
                       && (out_wheel_speed_2 != 16'sh8000) && (out_wheel_speed_3 != 16'sh8000);

  // checks
  `MWSM_ASSERT_NEXT(a_accept_lands, clk, rst_n, in_valid && !in_stall, v1_r)
  `MWSM_ASSERT_IMP(a_divisor_nonzero, clk, rst_n, v3_r && req3_r.scale, req3_r.divisor != '0)
  `MWSM_ASSERT_IMP(a_no_min_neg, clk, rst_n, out_valid, out_no_min_neg)
  `MWSM_ASSERT_IMP(a_reset_empty, clk, rst_n, !$past(rst_n), !out_valid && !v1_r)

endmodule

`default_nettype wire

FILE: rtl/core/mwsm_div_pipe.sv
// pipelined restoring divider, four lanes sharing one divisor
// depends on mwsm_pkg
`default_nettype none

module mwsm_div_pipe #(
  parameter int BITS_PER_STAGE = mwsm_pkg::DIV_BITS_DEFAULT
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire mwsm_pkg::div_req_t in_req,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output mwsm_pkg::div_req_t     out_req
);

  localparam int NST = (mwsm_pkg::QUOT_W + BITS_PER_STAGE - 1) / BITS_PER_STAGE;
  localparam int MW  = mwsm_pkg::MAG_W;

  logic               valid_r [NST];
  mwsm_pkg::div_req_t req_r   [NST];
  mwsm_pkg::div_req_t req_nxt [NST];
  logic               stg_in_valid [NST];
  mwsm_pkg::div_req_t stg_in_req   [NST];
  logic               rdy [NST];

  for (genvar s = 0; s < NST; s++) begin : g_stage
    // stage input source and ready chain
    if (s == 0) begin : g_first
      assign stg_in_valid[s] = in_valid;
      assign stg_in_req[s]   = in_req;
    end else begin : g_next
      assign stg_in_valid[s] = valid_r[s-1];
      assign stg_in_req[s]   = req_r[s-1];
    end
    if (s == NST - 1) begin : g_last
      assign rdy[s] = !valid_r[s] || !out_stall;
    end else begin : g_mid
      assign rdy[s] = !valid_r[s] || rdy[s+1];
    end

    // up to BITS_PER_STAGE shift-compare-subtract steps per lane
    always_comb begin
      logic [MW:0]   trial;
      logic [MW-1:0] rem;
      logic          qbit;
      req_nxt[s] = stg_in_req[s];
      for (int l = 0; l < mwsm_pkg::NUM_WHEELS; l++) begin
        for (int b = 0; b < BITS_PER_STAGE; b++) begin
          trial = req_nxt[s].work[l][mwsm_pkg::PROD_W-1:MW-1];
          qbit  = (trial >= {1'b0, req_nxt[s].divisor});
          rem   = qbit ? MW'(trial - {1'b0, req_nxt[s].divisor}) : trial[MW-1:0];
          if ((s * BITS_PER_STAGE + b) < mwsm_pkg::QUOT_W) begin
            req_nxt[s].work[l] = {rem, req_nxt[s].work[l][MW-2:0], qbit};
          end
        end
      end
    end

    // stage valid
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[s] <= 1'b0;
      end else if (rdy[s]) begin
        valid_r[s] <= stg_in_valid[s];
      end
    end

    // stage payload
    always_ff @(posedge clk) begin
      if (rdy[s] && stg_in_valid[s]) begin
        req_r[s] <= req_nxt[s];
      end
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = valid_r[NST-1];
  assign out_req   = req_r[NST-1];

endmodule

`default_nettype wire
